FILE: rtl/rms_and_sra_of_three_samples_macros.svh
// Assertion macros shared by the RTL files of the RMS and SRA block.
// Depends on nothing; included by the files that carry assertions.
`ifndef RMS_AND_SRA_OF_THREE_SAMPLES_MACROS_SVH
`define RMS_AND_SRA_OF_THREE_SAMPLES_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RMSSRA_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rmssra assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RMSSRA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rmssra assertion failed");

`endif

FILE: rtl/rmssra_pkg.sv
// Package of the RMS and SRA block: field widths, fixed-point constants
// and the state type of the pipelined square-root unit. No dependencies.
`timescale 1ns / 1ps

package rmssra_pkg;

  // Port fields.
  localparam int SAMPLE_W = 17;
  localparam int LEVEL_W  = 17;

  // Fixed-point format of a sample: 1.0 equals 2^SAMPLE_FRAC_BITS.
  localparam int SAMPLE_FRAC_BITS = 15;
  localparam int MAG_W            = SAMPLE_FRAC_BITS + 1;
  localparam int MAG_ONE          = 1 << SAMPLE_FRAC_BITS;
  localparam int MAG_SHIFT        = 32 - SAMPLE_FRAC_BITS;

  // Division of a magnitude by three through a reciprocal.
  localparam int QUOT3_W      = 14;
  localparam int RECIP3       = 43691;
  localparam int RECIP3_SHIFT = 17;

  // Division by nine of the squared root sum, after dropping 16 bits.
  localparam int RECIP9       = 1864136;
  localparam int RECIP9_W     = 21;
  localparam int RECIP9_SHIFT = 24;

  // Intermediate widths.
  localparam int PROD_W    = 29;
  localparam int BSQ_W     = 4;
  localparam int MEAN_W    = 33;
  localparam int RTSUM_W   = 18;
  localparam int RTSQ_W    = 2 * RTSUM_W;
  localparam int SRA_LOW   = 16;

  // Pipelined integer square root.
  localparam int SQRT_IN_W   = 34;
  localparam int SQRT_ROOT_W = SQRT_IN_W / 2;
  localparam int SQRT_REM_W  = SQRT_ROOT_W + 2;
  localparam int SQRT_STEPS  = 6;
  localparam int SQRT_STAGES = (SQRT_ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;

  typedef logic [SQRT_STAGES-1:0] sqrt_en_t;

  typedef struct packed {
    logic [SQRT_REM_W-1:0]  rem;
    logic [SQRT_ROOT_W-1:0] root;
    logic [SQRT_IN_W-1:0]   rad;
  } sqrt_state_t;

endpackage

FILE: rtl/rmssra_isqrt.sv
// Pipelined integer square root, rounded down, a few result bits per stage.
// Depends on rmssra_pkg; stage enables come from the caller's pipeline.
`timescale 1ns / 1ps

module rmssra_isqrt (
  input  logic                                clk_i,
  input  rmssra_pkg::sqrt_en_t                en_i,
  input  logic [rmssra_pkg::SQRT_IN_W-1:0]    radicand_i,
  output logic [rmssra_pkg::SQRT_ROOT_W-1:0]  root_o
);
  import rmssra_pkg::*;

  // One restoring step: bring down two radicand bits, try root*4+1.
  function automatic sqrt_state_t sqrt_step(input sqrt_state_t st);
    logic [SQRT_REM_W+1:0] cur;
    logic [SQRT_REM_W+1:0] trial;
    sqrt_state_t           nx;
    cur     = {st.rem, st.rad[SQRT_IN_W-1 -: 2]};
    trial   = {{(SQRT_REM_W - SQRT_ROOT_W){1'b0}}, st.root, 2'b01};
    nx.rad  = {st.rad[SQRT_IN_W-3:0], 2'b00};
    if (cur >= trial) begin
      nx.rem  = SQRT_REM_W'(cur - trial);
      nx.root = {st.root[SQRT_ROOT_W-2:0], 1'b1};
    end else begin
      nx.rem  = cur[SQRT_REM_W-1:0];
      nx.root = {st.root[SQRT_ROOT_W-2:0], 1'b0};
    end
    return nx;
  endfunction

  sqrt_state_t st_in [SQRT_STAGES];
  sqrt_state_t st_q  [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    sqrt_state_t st_d;

    if (s == 0) begin : g_first
      assign st_in[s] = '{rem: '0, root: '0, rad: radicand_i};
    end else begin : g_next
      assign st_in[s] = st_q[s-1];
    end

    always_comb begin
      st_d = st_in[s];
      for (int j = 0; j < SQRT_STEPS; j++) begin
        if (s * SQRT_STEPS + j < SQRT_ROOT_W) begin
          st_d = sqrt_step(st_d);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        st_q[s] <= st_d;
      end
    end
  end

  assign root_o = st_q[SQRT_STAGES-1].root;

endmodule

FILE: rtl/rms_and_sra_of_three_samples.sv
// RMS and square root amplitude of three samples; uses rmssra_pkg and rmssra_isqrt.
// Throughput: one beat per cycle unless the output stalls; each of the eight
// stages holds one beat and a stage takes a new beat whenever it is empty
// or its own beat moves on. Reset (rst_ni, asynchronous, active low) clears
// the stage valid bits only; the data registers are not reset.
`timescale 1ns / 1ps

`include "rms_and_sra_of_three_samples_macros.svh"

module rms_and_sra_of_three_samples (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [rmssra_pkg::SAMPLE_W-1:0] sample_a_i,
  input  logic signed [rmssra_pkg::SAMPLE_W-1:0] sample_b_i,
  input  logic signed [rmssra_pkg::SAMPLE_W-1:0] sample_c_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [rmssra_pkg::LEVEL_W-1:0]         rms_level_o,
  output logic [rmssra_pkg::LEVEL_W-1:0]         sra_level_o
);
  import rmssra_pkg::*;

  // Stage map:
  //   1  clamped magnitudes
  //   2  magnitude divided by three; square-root lanes start
  //   3  remainder b and factor 3a+2b
  //   4  products a*(3a+2b); square-root lanes finish
  //   5  mean square floor(4S/3) and the sum of the three roots
  //   6  square of the root sum; RMS square root starts
  //   7  division by 589824
  //   8  output register for both levels; RMS square root finishes
  localparam int NUM_STAGES = 8;
  localparam int NUM_LANES  = 3;

  // Magnitude of a two's complement field, clamped to 1.0. The most
  // negative code negates to itself as an unsigned value and is clamped too.
  function automatic logic [MAG_W-1:0] clamp_mag(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] abs_v;
    abs_v = s[SAMPLE_W-1] ? (~s + SAMPLE_W'(1)) : s;
    if (abs_v > SAMPLE_W'(MAG_ONE)) begin
      return MAG_W'(MAG_ONE);
    end
    return abs_v[MAG_W-1:0];
  endfunction

  // floor(4*n/3) for the small sum of squared remainders (at most 12).
  function automatic logic [4:0] four_thirds(input logic [BSQ_W-1:0] n);
    logic [4:0] r;
    unique case (n)
      4'd0:    r = 5'd0;
      4'd1:    r = 5'd1;
      4'd2:    r = 5'd2;
      4'd3:    r = 5'd4;
      4'd4:    r = 5'd5;
      4'd5:    r = 5'd6;
      4'd6:    r = 5'd8;
      4'd7:    r = 5'd9;
      4'd8:    r = 5'd10;
      4'd9:    r = 5'd12;
      4'd10:   r = 5'd13;
      4'd11:   r = 5'd14;
      4'd12:   r = 5'd16;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Handshake. A stage may load when it is empty or when its beat moves
  // on in the same cycle, so a bubble anywhere lets a new beat in even
  // while the output register holds a result that has not been taken.
  // ------------------------------------------------------------------
  logic [NUM_STAGES:1] vld_q;
  logic [NUM_STAGES:1] vld_in;
  logic [NUM_STAGES:1] en;

  always_comb begin
    en[NUM_STAGES] = !vld_q[NUM_STAGES] || out_ready_i;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign vld_in = {vld_q[NUM_STAGES-1:1], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = vld_q[NUM_STAGES];

  // ------------------------------------------------------------------
  // Stage 1: clamped magnitudes of the three samples.
  // ------------------------------------------------------------------
  logic [SAMPLE_W-1:0] samp [NUM_LANES];
  logic [MAG_W-1:0]    mag1_q [NUM_LANES];

  assign samp[0] = sample_a_i;
  assign samp[1] = sample_b_i;
  assign samp[2] = sample_c_i;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        mag1_q[i] <= clamp_mag(samp[i]);
      end
    end
  end

  // ------------------------------------------------------------------
  // RMS path. With m = 3a + b, m^2 = 3(3a^2 + 2ab) + b^2, so
  // floor(4S/3) = 4 * sum(a(3a+2b)) + floor(4 * sum(b^2) / 3), which
  // avoids dividing the wide sum of squares by three.
  // ------------------------------------------------------------------
  logic [MAG_W-1:0]   mag2_q  [NUM_LANES];
  logic [QUOT3_W-1:0] quo2_q  [NUM_LANES];
  logic [QUOT3_W-1:0] quo3_q  [NUM_LANES];
  logic [MAG_W-1:0]   fac3_q  [NUM_LANES];
  logic [BSQ_W-1:0]   bsq3_q;
  logic [PROD_W-1:0]  prod4_q [NUM_LANES];
  logic [BSQ_W-1:0]   bsq4_q;
  logic [MEAN_W-1:0]  mean5_q;

  logic [31:0]        recip_prod [NUM_LANES];
  logic [MAG_W-1:0]   rem_full   [NUM_LANES];
  logic [1:0]         rem3       [NUM_LANES];
  logic [BSQ_W-1:0]   bsq_d;
  logic [MEAN_W-1:0]  psum;

  always_comb begin
    bsq_d = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      recip_prod[i] = 32'(mag1_q[i]) * 32'(RECIP3);
      rem_full[i]   = mag2_q[i] - MAG_W'(MAG_W'(quo2_q[i]) * MAG_W'(3));
      rem3[i]       = rem_full[i][1:0];
      bsq_d         = bsq_d + BSQ_W'({2'b00, rem3[i]} * {2'b00, rem3[i]});
    end
    psum = MEAN_W'(prod4_q[0]) + MEAN_W'(prod4_q[1]) + MEAN_W'(prod4_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        mag2_q[i] <= mag1_q[i];
        quo2_q[i] <= recip_prod[i][RECIP3_SHIFT +: QUOT3_W];
      end
    end
    if (en[3]) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        quo3_q[i] <= quo2_q[i];
        fac3_q[i] <= mag2_q[i] + MAG_W'(rem3[i]);
      end
      bsq3_q <= bsq_d;
    end
    if (en[4]) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        prod4_q[i] <= PROD_W'(32'(quo3_q[i]) * 32'(fac3_q[i]));
      end
      bsq4_q <= bsq3_q;
    end
    if (en[5]) begin
      mean5_q <= (psum << 2) + MEAN_W'(four_thirds(bsq4_q));
    end
  end

  rmssra_isqrt u_rms_sqrt (
    .clk_i      (clk_i),
    .en_i       (sqrt_en_t'(en[8:6])),
    .radicand_i (SQRT_IN_W'(mean5_q)),
    .root_o     (rms_level_o)
  );

  // ------------------------------------------------------------------
  // SRA path: one square-root lane per sample on |t| * 2^17, then the
  // squared sum divided by 589824 = 9 * 2^16, the nine by a reciprocal.
  // ------------------------------------------------------------------
  logic [SQRT_ROOT_W-1:0] lane_root [NUM_LANES];
  logic [RTSUM_W-1:0]     rtsum5_q;
  logic [RTSQ_W-1:0]      rtsq6_q;
  logic [LEVEL_W-1:0]     sra7_q;
  logic [LEVEL_W-1:0]     sra8_q;
  logic [RTSQ_W-SRA_LOW+RECIP9_W-1:0] div9_prod;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    rmssra_isqrt u_mag_sqrt (
      .clk_i      (clk_i),
      .en_i       (sqrt_en_t'(en[4:2])),
      .radicand_i (SQRT_IN_W'({mag1_q[i], {MAG_SHIFT{1'b0}}})),
      .root_o     (lane_root[i])
    );
  end

  assign div9_prod = (RTSQ_W-SRA_LOW+RECIP9_W)'(rtsq6_q[RTSQ_W-1:SRA_LOW])
                   * (RTSQ_W-SRA_LOW+RECIP9_W)'(RECIP9);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      rtsum5_q <= RTSUM_W'(lane_root[0]) + RTSUM_W'(lane_root[1])
                + RTSUM_W'(lane_root[2]);
    end
    if (en[6]) begin
      rtsq6_q <= RTSQ_W'(rtsum5_q) * RTSQ_W'(rtsum5_q);
    end
    if (en[7]) begin
      sra7_q <= div9_prod[RECIP9_SHIFT +: LEVEL_W];
    end
    if (en[8]) begin
      sra8_q <= sra7_q;
    end
  end

  assign sra_level_o = sra8_q;

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  `RMSSRA_ASSERT_NOW(a_bubble_gives_ready, clk_i, rst_ni, vld_q != '1, in_ready_o)
  `RMSSRA_ASSERT_NOW(a_quot3_exact, clk_i, rst_ni, vld_q[2], (18'(quo2_q[0]) * 18'd3 <= 18'(mag2_q[0])) && (18'(mag2_q[0]) - 18'(quo2_q[0]) * 18'd3 < 18'd3))
  `RMSSRA_ASSERT_NOW(a_mean_in_range, clk_i, rst_ni, vld_q[5], mean5_q <= 33'h1_0000_0000)
  `RMSSRA_ASSERT_NOW(a_levels_in_range, clk_i, rst_ni, out_valid_o, (rms_level_o <= 17'h10000) && (sra_level_o <= 17'h10000))
  `RMSSRA_ASSERT_NEXT(a_last_stage_fills, clk_i, rst_ni, en[NUM_STAGES] && vld_q[NUM_STAGES-1], out_valid_o)

endmodule
